// ===== sv/sha_pkg.sv =====
// Package: SHA-256 hasher types, constants and round functions
`timescale 1ns / 1ps
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        final_word;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } state_t;

    // Control from sequencer to round unit
    typedef struct packed {
        logic       load;
        logic       round;
        logic [5:0] rnd;
    } rnd_ctrl_t;

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha_round.sv =====
// Shared round unit: schedule window, working variables, one round per cycle
`timescale 1ns / 1ps
module sha_round (
    input  logic                  clk,
    input  sha_pkg::rnd_ctrl_t    ctrl,
    input  logic [31:0]           blk_word [16],
    input  logic [31:0]           hash_in  [8],
    output logic [31:0]           vars_out [8]
);
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [31:0] w2, w7, w15, w16, wv, s0, s1, t1, t2, ch, maj, e1, e0;

    // Form the schedule word for this round
    always_comb
    begin
        w2  = w_reg[ctrl.rnd[3:0] - 4'd2];
        w7  = w_reg[ctrl.rnd[3:0] - 4'd7];
        w15 = w_reg[ctrl.rnd[3:0] - 4'd15];
        w16 = w_reg[ctrl.rnd[3:0]];
        s1 = sha_pkg::rotr(w2, 17) ^ sha_pkg::rotr(w2, 19) ^ (w2 >> 10);
        s0 = sha_pkg::rotr(w15, 7) ^ sha_pkg::rotr(w15, 18) ^ (w15 >> 3);
        if (ctrl.rnd[5:4] == 2'd0)
            wv = blk_word[ctrl.rnd[3:0]];
        else
            wv = s1 + w7 + s0 + w16;
        e1  = sha_pkg::rotr(v_reg[4], 6) ^ sha_pkg::rotr(v_reg[4], 11)
            ^ sha_pkg::rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        e0  = sha_pkg::rotr(v_reg[0], 2) ^ sha_pkg::rotr(v_reg[0], 13)
            ^ sha_pkg::rotr(v_reg[0], 22);
        maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t1  = v_reg[7] + e1 + ch + sha_pkg::ROUND_K[ctrl.rnd] + wv;
        t2  = e0 + maj;
    end

    // Load or advance the round state
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            v_reg <= hash_in;
        end
        else if (ctrl.round)
        begin
            w_reg[ctrl.rnd[3:0]] <= wv;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    assign vars_out = v_reg;
endmodule

// ===== sv/sha256_message_hasher.sv =====
// Top level: SHA-256 byte-stream hasher with padding sequencer
// A byte that does not fill a block is taken while idle; a byte that fills
// a block stalls the input through load, 64 rounds in the shared round unit and fold.
// A last item adds a padding step before each final block, one or two such compressions and
// then eight digest transfers, one per cycle while out_stall is low.
// Reset (rst_n, asynchronous) clears the sequencer and byte count and loads the initial hash.
`timescale 1ns / 1ps
module sha256_message_hasher (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  sha_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output sha_pkg::out_item_t  out_data
);
    sha_pkg::state_t state_reg, state_next;
    logic [31:0] hash_reg [8];
    logic [31:0] blk_reg  [16];
    logic [60:0] cnt_reg;
    logic [5:0]  rnd_reg, rnd_next;
    logic [5:0]  pos_reg, pos_next;
    logic        last_reg, last_next;
    logic        two_reg, two_next;
    logic        fin_reg, fin_next;
    logic [2:0]  oi_reg, oi_next;
    logic [31:0] vars [8];
    sha_pkg::rnd_ctrl_t ctrl;
    logic        acc, accb, fold, restore;
    logic [5:0]  cpos;
    logic [63:0] bits;

    assign acc  = in_valid && !in_stall;
    assign accb = acc && in_data.byte_valid;
    assign cpos = cnt_reg[5:0];
    assign bits = {cnt_reg, 3'b000};

    sha_round u_round (
        .clk      (clk),
        .ctrl     (ctrl),
        .blk_word (blk_reg),
        .hash_in  (hash_reg),
        .vars_out (vars)
    );

    // Sequencer: next state and controls
    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        pos_next   = pos_reg;
        last_next  = last_reg;
        two_next   = two_reg;
        fin_next   = fin_reg;
        oi_next    = oi_reg;
        ctrl       = '{load: 1'b0, round: 1'b0, rnd: rnd_reg};
        fold       = 1'b0;
        restore    = 1'b0;
        in_stall   = (state_reg != sha_pkg::ST_IDLE);
        out_valid  = (state_reg == sha_pkg::ST_OUT);
        case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (acc)
                begin
                    last_next = in_data.is_last;
                    pos_next  = accb ? cpos + 6'd1 : cpos;
                    if (accb && cpos == 6'd63)
                        state_next = sha_pkg::ST_LOAD;
                    else if (in_data.is_last)
                        state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                // length-only block, single final block, or spill into a second block
                if (two_reg)
                begin
                    two_next = 1'b0;
                    fin_next = 1'b1;
                end
                else if (pos_reg >= sha_pkg::LEN_POS)
                    two_next = 1'b1;
                else
                    fin_next = 1'b1;
                state_next = sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_LOAD:
            begin
                ctrl.load  = 1'b1;
                rnd_next   = 6'd0;
                state_next = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND:
            begin
                ctrl.round = 1'b1;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = sha_pkg::ST_FOLD;
            end
            sha_pkg::ST_FOLD:
            begin
                fold = 1'b1;
                if (fin_reg)
                begin
                    fin_next   = 1'b0;
                    oi_next    = 3'd0;
                    state_next = sha_pkg::ST_OUT;
                end
                else if (last_reg)
                    state_next = sha_pkg::ST_PAD;
                else
                    state_next = sha_pkg::ST_IDLE;
            end
            sha_pkg::ST_OUT:
            begin
                if (!out_stall)
                begin
                    oi_next = oi_reg + 3'd1;
                    if (oi_reg == 3'd7)
                    begin
                        restore    = 1'b1;
                        last_next  = 1'b0;
                        state_next = sha_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = sha_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_data.digest_word = hash_reg[oi_reg];
    assign out_data.word_index  = oi_reg;
    assign out_data.final_word  = (oi_reg == 3'd7);

    // Hold control state, byte count and hash
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sha_pkg::ST_IDLE;
            rnd_reg   <= '0;
            pos_reg   <= '0;
            last_reg  <= 1'b0;
            two_reg   <= 1'b0;
            fin_reg   <= 1'b0;
            oi_reg    <= '0;
            cnt_reg   <= '0;
            hash_reg  <= sha_pkg::H_INIT;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            pos_reg   <= pos_next;
            last_reg  <= last_next;
            two_reg   <= two_next;
            fin_reg   <= fin_next;
            oi_reg    <= oi_next;
            if (accb)
                cnt_reg <= cnt_reg + 61'd1;
            if (fold)
            begin
                for (int i = 0; i < 8; i++)
                    hash_reg[i] <= hash_reg[i] + vars[i];
            end
            if (restore)
            begin
                hash_reg <= sha_pkg::H_INIT;
                cnt_reg  <= '0;
            end
        end
    end

    // Write message bytes and padding into the block buffer
    always_ff @(posedge clk)
    begin
        if (accb)
            blk_reg[cpos[5:2]][8 * (3 - cpos[1:0]) +: 8] <= in_data.data_byte;
        if (state_reg == sha_pkg::ST_PAD)
        begin
            for (int b = 0; b < 64; b++)
            begin
                if (two_reg)
                    blk_reg[b / 4][8 * (3 - b % 4) +: 8] <= 8'h00;
                else if (b[5:0] == pos_reg)
                    blk_reg[b / 4][8 * (3 - b % 4) +: 8] <= sha_pkg::PAD_BYTE;
                else if (b[5:0] > pos_reg)
                    blk_reg[b / 4][8 * (3 - b % 4) +: 8] <= 8'h00;
            end
            if (pos_reg < sha_pkg::LEN_POS || two_reg)
            begin
                blk_reg[14] <= bits[63:32];
                blk_reg[15] <= bits[31:0];
            end
        end
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall) else $error("output while accepting input");
    a_final_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_data.final_word) |=> !out_valid)
        else $error("extra digest word");
    a_round_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sha_pkg::ST_LOAD) |=> (rnd_reg == 6'd0))
        else $error("round counter not cleared");
endmodule
